FILE: rtl/core/jvrl_pkg.sv
// ----------------------------------------------------------------------------
// Joint velocity ramp limiter package
// Shared types and constants for the velocity ramp pipeline.
// ----------------------------------------------------------------------------
package jvrl_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam logic [15:0] EIGHT_TENTHS = 16'd52429;

    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_VLIM  = 2'd1;
    localparam logic [1:0] REG_TSTEP = 2'd2;
    localparam logic [1:0] REG_DBAND = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        logic signed [31:0] target;
        logic signed [31:0] cur;
        logic signed [31:0] vmin;
        logic signed [31:0] vmax;
    } sqrt_cell_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/jvrl_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root, handing its result on.
// ----------------------------------------------------------------------------
module jvrl_sqrt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  jvrl_pkg::sqrt_cell_t cell_in,
    output jvrl_pkg::sqrt_cell_t cell_out
);

    jvrl_pkg::sqrt_cell_t cell_reg;
    jvrl_pkg::sqrt_cell_t cell_next;
    logic [63:0] trial;

    always_comb
    begin
        cell_next = cell_in;
        trial = cell_in.root + cell_in.bitv;
        if (cell_in.rem >= trial)
        begin
            cell_next.rem  = cell_in.rem - trial;
            cell_next.root = (cell_in.root >> 1) + cell_in.bitv;
        end
        else
        begin
            cell_next.root = cell_in.root >> 1;
        end
        cell_next.bitv = cell_in.bitv >> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

FILE: rtl/core/joint_velocity_ramp_limiter.sv
// ----------------------------------------------------------------------------
// Joint velocity ramp limiter
// Done follows start through the registered stages; one item may start every cycle.
// The chain of 32 square root cells sets the latency.
// busy is always low; results cannot be stalled.
// Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module joint_velocity_ramp_limiter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] target_position,
    input  logic signed [31:0] current_position,
    input  logic signed [31:0] current_velocity,
    output logic               done,
    output logic signed [31:0] velocity_command,
    output logic signed [31:0] position_command,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [30:0] accel_reg;
    logic [30:0] vlim_reg;
    logic [16:0] tstep_reg;
    logic [15:0] dband_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= 31'd65536;
            vlim_reg  <= 31'd65536;
            tstep_reg <= 17'd655;
            dband_reg <= 16'd655;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                jvrl_pkg::REG_ACCEL: accel_reg <= cfg_data[30:0];
                jvrl_pkg::REG_VLIM:  vlim_reg  <= cfg_data[30:0];
                jvrl_pkg::REG_TSTEP: tstep_reg <= cfg_data[16:0];
                jvrl_pkg::REG_DBAND: dband_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Stage 1: distance, deadband, velocity step.
    logic               s1_valid_reg;
    logic               s1_neg_reg;
    logic [31:0]        s1_mag_reg;
    logic [47:0]        s1_dv_reg;
    logic signed [31:0] s1_tgt_reg;
    logic signed [31:0] s1_cur_reg;
    logic signed [31:0] s1_vcur_reg;
    logic signed [31:0] distance;
    logic [31:0]        mag;
    logic [47:0]        dv_full;

    always_comb
    begin
        distance = jvrl_pkg::sat32(34'(target_position) - 34'(current_position));
        mag = distance[31] ? 32'(-33'(distance)) : 32'(distance);
        dv_full = 48'(accel_reg) * 48'(tstep_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tgt_reg  <= target_position;
        s1_cur_reg  <= current_position;
        s1_vcur_reg <= current_velocity;
        s1_dv_reg   <= dv_full;
        if (mag < 32'(dband_reg))
        begin
            s1_mag_reg <= '0;
            s1_neg_reg <= 1'b0;
        end
        else
        begin
            s1_mag_reg <= mag;
            s1_neg_reg <= distance[31];
        end
    end

    // Stage 2: product and velocity window.
    logic               s2_valid_reg;
    jvrl_pkg::sqrt_cell_t s2_cell_reg;
    logic [63:0]        prod;
    logic [31:0]        dv32;
    logic signed [31:0] vmin;
    logic signed [31:0] vmax;
    logic signed [31:0] nvlim;

    always_comb
    begin
        prod = 64'(s1_mag_reg) * 64'(accel_reg);
        prod = prod << 1;
        dv32 = s1_dv_reg[47:16];
        nvlim = -32'(vlim_reg);
        vmin = jvrl_pkg::sat32(34'(s1_vcur_reg) - $signed({2'b00, dv32}));
        if (vmin < nvlim)
            vmin = nvlim;
        vmax = jvrl_pkg::sat32(34'(s1_vcur_reg) + $signed({2'b00, dv32}));
        if (vmax > $signed({1'b0, vlim_reg}))
            vmax = $signed({1'b0, vlim_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cell_reg.valid  <= 1'b0;
        s2_cell_reg.neg    <= s1_neg_reg;
        s2_cell_reg.rem    <= prod;
        s2_cell_reg.root   <= '0;
        s2_cell_reg.bitv   <= 64'h4000_0000_0000_0000;
        s2_cell_reg.target <= s1_tgt_reg;
        s2_cell_reg.cur    <= s1_cur_reg;
        s2_cell_reg.vmin   <= vmin;
        s2_cell_reg.vmax   <= vmax;
    end

    jvrl_pkg::sqrt_cell_t chain [jvrl_pkg::SQRT_STEPS+1];
    always_comb
    begin
        chain[0] = s2_cell_reg;
        chain[0].valid = s2_valid_reg;
    end

    genvar g;
    generate
        for (g = 0; g < jvrl_pkg::SQRT_STEPS; g++)
        begin : g_cell
            jvrl_sqrt_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_in  (chain[g]),
                .cell_out (chain[g+1])
            );
        end
    endgenerate

    jvrl_pkg::sqrt_cell_t last;
    assign last = chain[jvrl_pkg::SQRT_STEPS];

    // Scale by 0.8.
    logic               s3_valid_reg;
    logic [47:0]        s3_m_reg;
    logic               s3_neg_reg;
    logic signed [31:0] s3_tgt_reg;
    logic signed [31:0] s3_cur_reg;
    logic signed [31:0] s3_vmin_reg;
    logic signed [31:0] s3_vmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_m_reg    <= last.root[31:0] * 48'(jvrl_pkg::EIGHT_TENTHS);
        s3_neg_reg  <= last.neg;
        s3_tgt_reg  <= last.target;
        s3_cur_reg  <= last.cur;
        s3_vmin_reg <= last.vmin;
        s3_vmax_reg <= last.vmax;
    end

    // Clamp the command.
    logic               s4_valid_reg;
    logic signed [31:0] s4_cmd_reg;
    logic signed [31:0] s4_tgt_reg;
    logic signed [31:0] s4_cur_reg;
    logic [31:0]        m32;
    logic signed [31:0] vdist;
    logic signed [31:0] cmd;

    always_comb
    begin
        m32 = s3_m_reg[47:16];
        if (s3_neg_reg)
            vdist = (m32 > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-33'({1'b0, m32}));
        else
            vdist = m32[31] ? 32'sh7FFF_FFFF : $signed(m32);
        cmd = vdist;
        if (cmd < s3_vmin_reg)
            cmd = s3_vmin_reg;
        if (cmd > s3_vmax_reg)
            cmd = s3_vmax_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_cmd_reg <= cmd;
        s4_tgt_reg <= s3_tgt_reg;
        s4_cur_reg <= s3_cur_reg;
    end

    // Next position and overshoot clamp.
    logic               out_valid_reg;
    logic signed [31:0] out_vel_reg;
    logic signed [31:0] out_pos_reg;
    logic signed [31:0] q;

    always_comb
    begin
        q = jvrl_pkg::sat32(34'(s4_cur_reg) + 34'(s4_cmd_reg));
        if (s4_cmd_reg > 0 && s4_tgt_reg < q)
            q = s4_tgt_reg;
        else if (s4_cmd_reg < 0 && s4_tgt_reg > q)
            q = s4_tgt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_vel_reg <= s4_cmd_reg;
        out_pos_reg <= q;
    end

    assign done = out_valid_reg;
    assign velocity_command = out_vel_reg;
    assign position_command = out_pos_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start, 37) && $past(rst_n, 37) |-> done)
        else $error("Result missing after start.");

    a_pos_toward_target: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && s4_cmd_reg > 0 |=> out_pos_reg <= $past(s4_tgt_reg)
            || out_pos_reg <= $past(s4_cur_reg))
        else $error("Position passed the target.");

    a_cmd_window: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_vmin_reg <= s3_vmax_reg |=>
            s4_cmd_reg >= $past(s3_vmin_reg) && s4_cmd_reg <= $past(s3_vmax_reg))
        else $error("Command outside velocity window.");

endmodule
